FILE: hw/rtl/tlpid_pkg.sv
// ----------------------------------------------------------------------------
// tlpid_pkg
// Shared widths, constants and types of the three-lane PID controller with
// a sticky convergence flag.
// ----------------------------------------------------------------------------
`default_nettype none

package tlpid_pkg;

    localparam int LANES     = 3;
    localparam int LANE_W    = (LANES > 1) ? $clog2(LANES) : 1;

    localparam int CUR_W     = 16;
    localparam int ERR_W     = CUR_W + 1;
    localparam int DT_W      = 16;
    localparam int GAIN_W    = 20;
    localparam int CFG_W     = 60;
    localparam int TOL_W     = 15;
    localparam int INTEG_W   = 48;
    localparam int DRIVE_W   = 24;
    localparam int QUO_W     = ERR_W + 1;
    localparam int MAG_W     = QUO_W - 1;
    localparam int CNT_W     = $clog2(MAG_W + 1);

    localparam int FRAC_SH   = 10;
    localparam int INTEG_SH  = 20;
    localparam int IH_W      = INTEG_W - INTEG_SH;

    localparam int MUL_A_W   = IH_W + 1;
    localparam int MUL_B_W   = GAIN_W + 1;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int ACC_W     = INTEG_W + 1;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = CFG_IDX_W'(3);

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(205);

    localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};
    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = {1'b0, {(DRIVE_W-1){1'b1}}};
    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = {1'b1, {(DRIVE_W-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_ED,
        S_INT,
        S_P,
        S_IH,
        S_IL,
        S_ILA,
        S_DW,
        S_DA,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        MUL_ED,
        MUL_P,
        MUL_IH,
        MUL_IL,
        MUL_D
    } t_mul_sel;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD_P,
        ACC_ADD,
        ACC_ADD_LOW,
        ACC_DRIVE
    } t_acc_op;

    typedef struct packed {
        logic              capture;
        logic              check;
        logic              mul_en;
        t_mul_sel          mul_sel;
        t_acc_op           acc_op;
        logic              integ_wr;
        logic              div_start;
        logic              out_load;
        logic [LANE_W-1:0] lane;
    } t_dp_cmd;

    typedef struct packed {
        logic all_in;
        logic div_busy;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

FILE: hw/rtl/tlpid_div.sv
// ----------------------------------------------------------------------------
// tlpid_div
// Serial restoring divider for the derivative term, one quotient bit per
// cycle, truncating toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpid_div (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic signed [tlpid_pkg::QUO_W-1:0] i_dividend,
    input  wire logic        [tlpid_pkg::DT_W-1:0]  i_divisor,
    output logic                                    o_busy,
    output logic signed      [tlpid_pkg::QUO_W-1:0] o_quotient
);

    logic                           r_busy;
    logic [tlpid_pkg::CNT_W-1:0]    r_cnt;
    logic [tlpid_pkg::MAG_W-1:0]    r_q;
    logic [tlpid_pkg::DT_W-1:0]     r_rem;
    logic [tlpid_pkg::DT_W-1:0]     r_den;
    logic                           r_neg;

    logic [tlpid_pkg::QUO_W-1:0]    abs_dividend;
    logic [tlpid_pkg::DT_W:0]       trial;
    logic [tlpid_pkg::DT_W:0]       trial_sub;
    logic                           fits;
    logic [tlpid_pkg::QUO_W-1:0]    mag_ext;

    assign abs_dividend = i_dividend[tlpid_pkg::QUO_W-1] ? -i_dividend : i_dividend;
    assign trial        = {r_rem, r_q[tlpid_pkg::MAG_W-1]};
    assign trial_sub    = trial - {1'b0, r_den};
    assign fits         = (trial >= {1'b0, r_den});
    assign mag_ext      = {1'b0, r_q};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + tlpid_pkg::CNT_W'(1);
            if (r_cnt == tlpid_pkg::CNT_W'(tlpid_pkg::MAG_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= abs_dividend[tlpid_pkg::MAG_W-1:0];
            r_rem <= '0;
            r_den <= i_divisor;
            r_neg <= i_dividend[tlpid_pkg::QUO_W-1];
        end else if (r_busy) begin
            r_rem <= fits ? trial_sub[tlpid_pkg::DT_W-1:0] : trial[tlpid_pkg::DT_W-1:0];
            r_q   <= {r_q[tlpid_pkg::MAG_W-2:0], fits};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_neg ? -mag_ext : mag_ext;

endmodule

`default_nettype wire

FILE: hw/rtl/tlpid_ctrl.sv
// ----------------------------------------------------------------------------
// tlpid_ctrl
// Controller state machine: sequences the convergence check and the per-lane
// multiply, accumulate and divide steps over the shared datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpid_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire tlpid_pkg::t_dp_sts i_sts,
    output logic                    o_ready,
    output tlpid_pkg::t_dp_cmd      o_cmd
);

    tlpid_pkg::t_state              r_state;
    tlpid_pkg::t_state              n_state;
    logic [tlpid_pkg::LANE_W-1:0]   r_lane;
    logic [tlpid_pkg::LANE_W-1:0]   n_lane;
    logic                           last_lane;

    assign last_lane = (r_lane == tlpid_pkg::LANE_W'(tlpid_pkg::LANES - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tlpid_pkg::S_IDLE;
            r_lane  <= '0;
        end else begin
            r_state <= n_state;
            r_lane  <= n_lane;
        end
    end

    always_comb begin
        n_state = r_state;
        n_lane  = r_lane;
        unique case (r_state)
            tlpid_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = tlpid_pkg::S_CHECK;
                end
            end
            tlpid_pkg::S_CHECK: begin
                n_lane  = '0;
                n_state = i_sts.all_in ? tlpid_pkg::S_OUT : tlpid_pkg::S_ED;
            end
            tlpid_pkg::S_ED:  n_state = tlpid_pkg::S_INT;
            tlpid_pkg::S_INT: n_state = tlpid_pkg::S_P;
            tlpid_pkg::S_P:   n_state = tlpid_pkg::S_IH;
            tlpid_pkg::S_IH:  n_state = tlpid_pkg::S_IL;
            tlpid_pkg::S_IL:  n_state = tlpid_pkg::S_ILA;
            tlpid_pkg::S_ILA: n_state = tlpid_pkg::S_DW;
            tlpid_pkg::S_DW: begin
                if (!i_sts.div_busy) begin
                    n_state = tlpid_pkg::S_DA;
                end
            end
            tlpid_pkg::S_DA: begin
                if (last_lane) begin
                    n_state = tlpid_pkg::S_OUT;
                end else begin
                    n_lane  = r_lane + tlpid_pkg::LANE_W'(1);
                    n_state = tlpid_pkg::S_ED;
                end
            end
            tlpid_pkg::S_OUT: begin
                if (i_sts.out_free) begin
                    n_state = tlpid_pkg::S_IDLE;
                end
            end
            default: n_state = tlpid_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_ready         = 1'b0;
        o_cmd.capture   = 1'b0;
        o_cmd.check     = 1'b0;
        o_cmd.mul_en    = 1'b0;
        o_cmd.mul_sel   = tlpid_pkg::MUL_ED;
        o_cmd.acc_op    = tlpid_pkg::ACC_HOLD;
        o_cmd.integ_wr  = 1'b0;
        o_cmd.div_start = 1'b0;
        o_cmd.out_load  = 1'b0;
        o_cmd.lane      = r_lane;
        unique case (r_state)
            tlpid_pkg::S_IDLE: begin
                o_ready       = 1'b1;
                o_cmd.capture = i_valid;
            end
            tlpid_pkg::S_CHECK: begin
                o_cmd.check = 1'b1;
            end
            tlpid_pkg::S_ED: begin
                o_cmd.mul_en    = 1'b1;
                o_cmd.mul_sel   = tlpid_pkg::MUL_ED;
                o_cmd.div_start = 1'b1;
            end
            tlpid_pkg::S_INT: begin
                o_cmd.integ_wr = 1'b1;
            end
            tlpid_pkg::S_P: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = tlpid_pkg::MUL_P;
            end
            tlpid_pkg::S_IH: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = tlpid_pkg::MUL_IH;
                o_cmd.acc_op  = tlpid_pkg::ACC_LOAD_P;
            end
            tlpid_pkg::S_IL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = tlpid_pkg::MUL_IL;
                o_cmd.acc_op  = tlpid_pkg::ACC_ADD;
            end
            tlpid_pkg::S_ILA: begin
                o_cmd.acc_op = tlpid_pkg::ACC_ADD_LOW;
            end
            tlpid_pkg::S_DW: begin
                o_cmd.mul_en  = !i_sts.div_busy;
                o_cmd.mul_sel = tlpid_pkg::MUL_D;
            end
            tlpid_pkg::S_DA: begin
                o_cmd.acc_op = tlpid_pkg::ACC_DRIVE;
            end
            tlpid_pkg::S_OUT: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/tlpid_dp.sv
// ----------------------------------------------------------------------------
// tlpid_dp
// Datapath: configuration registers, lane state, shared multiplier with
// accumulator, serial divider and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpid_dp (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire tlpid_pkg::t_dp_cmd                     i_cmd,
    output tlpid_pkg::t_dp_sts                          o_sts,
    input  wire logic                                   i_cfg_we,
    input  wire logic        [tlpid_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic        [tlpid_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic signed [tlpid_pkg::CUR_W-1:0]     i_target   [tlpid_pkg::LANES],
    input  wire logic signed [tlpid_pkg::CUR_W-1:0]     i_measured [tlpid_pkg::LANES],
    input  wire logic        [tlpid_pkg::DT_W-1:0]      i_elapsed_us,
    input  wire logic                                   i_ready,
    output logic                                        o_valid,
    output logic signed      [tlpid_pkg::DRIVE_W-1:0]   o_drive    [tlpid_pkg::LANES],
    output logic                                        o_command_valid,
    output logic                                        o_converged
);

    logic [tlpid_pkg::CFG_W-1:0]                r_gain_p;
    logic [tlpid_pkg::CFG_W-1:0]                r_gain_i;
    logic [tlpid_pkg::CFG_W-1:0]                r_gain_d;
    logic [tlpid_pkg::TOL_W-1:0]                r_tol;

    logic signed [tlpid_pkg::ERR_W-1:0]         r_err   [tlpid_pkg::LANES];
    logic [tlpid_pkg::DT_W-1:0]                 r_dt;
    logic signed [tlpid_pkg::INTEG_W-1:0]       r_integ [tlpid_pkg::LANES];
    logic signed [tlpid_pkg::ERR_W-1:0]         r_prev  [tlpid_pkg::LANES];
    logic                                       r_done;
    logic                                       r_res_cmd;
    logic signed [tlpid_pkg::PROD_W-1:0]        r_prod;
    logic signed [tlpid_pkg::ACC_W-1:0]         r_acc;
    logic signed [tlpid_pkg::DRIVE_W-1:0]       r_drive [tlpid_pkg::LANES];

    logic                                       r_out_valid;
    logic signed [tlpid_pkg::DRIVE_W-1:0]       r_out_drive [tlpid_pkg::LANES];
    logic                                       r_out_cmd;
    logic                                       r_out_conv;

    logic                                       all_in;
    logic                                       out_free;
    logic signed [tlpid_pkg::ERR_W-1:0]         cur_err;
    logic signed [tlpid_pkg::ERR_W-1:0]         cur_prev;
    logic signed [tlpid_pkg::INTEG_W-1:0]       cur_integ;
    logic signed [tlpid_pkg::IH_W-1:0]          cur_ih;
    logic signed [tlpid_pkg::GAIN_W-1:0]        gain_p;
    logic signed [tlpid_pkg::GAIN_W-1:0]        gain_i;
    logic signed [tlpid_pkg::GAIN_W-1:0]        gain_d;
    logic signed [tlpid_pkg::MUL_A_W-1:0]       mul_a;
    logic signed [tlpid_pkg::MUL_B_W-1:0]       mul_b;
    logic signed [tlpid_pkg::INTEG_W:0]         integ_sum;
    logic signed [tlpid_pkg::INTEG_W-1:0]       integ_next;
    logic signed [tlpid_pkg::ACC_W-1:0]         prod_full;
    logic signed [tlpid_pkg::ACC_W-1:0]         prod_frac;
    logic signed [tlpid_pkg::ACC_W-1:0]         prod_low;
    logic signed [tlpid_pkg::ACC_W-1:0]         drive_sum;
    logic signed [tlpid_pkg::DRIVE_W-1:0]       drive_next;
    logic signed [tlpid_pkg::QUO_W-1:0]         div_dividend;
    logic signed [tlpid_pkg::QUO_W-1:0]         div_quotient;
    logic                                       div_busy;

    function automatic logic signed [tlpid_pkg::GAIN_W-1:0] lane_gain(
        input logic [tlpid_pkg::CFG_W-1:0]  packed_g,
        input logic [tlpid_pkg::LANE_W-1:0] lane
    );
        logic signed [tlpid_pkg::GAIN_W-1:0] g;
        g = '0;
        for (int k = 0; k < tlpid_pkg::LANES; k++) begin
            if (lane == tlpid_pkg::LANE_W'(k) &&
                (k + 1) * tlpid_pkg::GAIN_W <= tlpid_pkg::CFG_W) begin
                g = tlpid_pkg::GAIN_W'(packed_g >> (k * tlpid_pkg::GAIN_W));
            end
        end
        return g;
    endfunction

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p <= '0;
            r_gain_i <= '0;
            r_gain_d <= '0;
            r_tol    <= tlpid_pkg::TOL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tlpid_pkg::CFG_GAIN_P:    r_gain_p <= i_cfg_data;
                tlpid_pkg::CFG_GAIN_I:    r_gain_i <= i_cfg_data;
                tlpid_pkg::CFG_GAIN_D:    r_gain_d <= i_cfg_data;
                tlpid_pkg::CFG_TOLERANCE: r_tol    <= i_cfg_data[tlpid_pkg::TOL_W-1:0];
                default:                  r_tol    <= r_tol;
            endcase
        end
    end

    // Convergence test across all lanes.
    always_comb begin
        logic [tlpid_pkg::ERR_W-1:0] mag;
        all_in = 1'b1;
        for (int l = 0; l < tlpid_pkg::LANES; l++) begin
            mag = r_err[l][tlpid_pkg::ERR_W-1] ? -r_err[l] : r_err[l];
            if (mag >= {{(tlpid_pkg::ERR_W - tlpid_pkg::TOL_W){1'b0}}, r_tol}) begin
                all_in = 1'b0;
            end
        end
    end

    assign cur_err   = r_err[i_cmd.lane];
    assign cur_prev  = r_prev[i_cmd.lane];
    assign cur_integ = r_integ[i_cmd.lane];
    assign cur_ih    = cur_integ[tlpid_pkg::INTEG_W-1:tlpid_pkg::INTEG_SH];
    assign gain_p    = lane_gain(r_gain_p, i_cmd.lane);
    assign gain_i    = lane_gain(r_gain_i, i_cmd.lane);
    assign gain_d    = lane_gain(r_gain_d, i_cmd.lane);

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.mul_sel)
            tlpid_pkg::MUL_ED: begin
                mul_a = tlpid_pkg::MUL_A_W'(cur_err);
                mul_b = tlpid_pkg::MUL_B_W'({1'b0, r_dt});
            end
            tlpid_pkg::MUL_P: begin
                mul_a = tlpid_pkg::MUL_A_W'(cur_err);
                mul_b = tlpid_pkg::MUL_B_W'(gain_p);
            end
            tlpid_pkg::MUL_IH: begin
                mul_a = tlpid_pkg::MUL_A_W'(cur_ih);
                mul_b = tlpid_pkg::MUL_B_W'(gain_i);
            end
            tlpid_pkg::MUL_IL: begin
                mul_a = tlpid_pkg::MUL_A_W'({1'b0, cur_integ[tlpid_pkg::INTEG_SH-1:0]});
                mul_b = tlpid_pkg::MUL_B_W'(gain_i);
            end
            tlpid_pkg::MUL_D: begin
                mul_a = tlpid_pkg::MUL_A_W'(div_quotient);
                mul_b = tlpid_pkg::MUL_B_W'(gain_d);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Saturating integral update and drive clamp.
    always_comb begin
        integ_sum = (tlpid_pkg::INTEG_W + 1)'(cur_integ) + (tlpid_pkg::INTEG_W + 1)'(r_prod);
        if (integ_sum[tlpid_pkg::INTEG_W] != integ_sum[tlpid_pkg::INTEG_W-1]) begin
            integ_next = integ_sum[tlpid_pkg::INTEG_W] ? tlpid_pkg::INTEG_MIN
                                                       : tlpid_pkg::INTEG_MAX;
        end else begin
            integ_next = tlpid_pkg::INTEG_W'(integ_sum);
        end
    end

    assign prod_full = tlpid_pkg::ACC_W'(r_prod);
    assign prod_frac = tlpid_pkg::ACC_W'(r_prod >>> tlpid_pkg::FRAC_SH);
    assign prod_low  = tlpid_pkg::ACC_W'(r_prod >>> tlpid_pkg::INTEG_SH);
    assign drive_sum = r_acc + prod_frac;

    always_comb begin
        if (drive_sum > tlpid_pkg::ACC_W'(tlpid_pkg::DRIVE_MAX)) begin
            drive_next = tlpid_pkg::DRIVE_MAX;
        end else if (drive_sum < tlpid_pkg::ACC_W'(tlpid_pkg::DRIVE_MIN)) begin
            drive_next = tlpid_pkg::DRIVE_MIN;
        end else begin
            drive_next = tlpid_pkg::DRIVE_W'(drive_sum);
        end
    end

    assign div_dividend = {cur_err[tlpid_pkg::ERR_W-1], cur_err}
                        - {cur_prev[tlpid_pkg::ERR_W-1], cur_prev};

    tlpid_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_dt),
        .o_busy     (div_busy),
        .o_quotient (div_quotient)
    );

    // Lane state and the sticky flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < tlpid_pkg::LANES; l++) begin
                r_integ[l] <= '0;
                r_prev[l]  <= '0;
            end
            r_done    <= 1'b0;
            r_res_cmd <= 1'b0;
        end else begin
            if (i_cmd.integ_wr) begin
                r_integ[i_cmd.lane] <= integ_next;
            end
            if (i_cmd.div_start) begin
                r_prev[i_cmd.lane] <= cur_err;
            end
            if (i_cmd.check) begin
                r_res_cmd <= !all_in;
                if (all_in) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Tick capture, multiplier and accumulator.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            for (int l = 0; l < tlpid_pkg::LANES; l++) begin
                r_err[l] <= {i_target[l][tlpid_pkg::CUR_W-1], i_target[l]}
                          - {i_measured[l][tlpid_pkg::CUR_W-1], i_measured[l]};
            end
            r_dt <= (i_elapsed_us == '0) ? tlpid_pkg::DT_W'(1) : i_elapsed_us;
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        unique case (i_cmd.acc_op)
            tlpid_pkg::ACC_HOLD:    r_acc <= r_acc;
            tlpid_pkg::ACC_LOAD_P:  r_acc <= prod_frac;
            tlpid_pkg::ACC_ADD:     r_acc <= r_acc + prod_full;
            tlpid_pkg::ACC_ADD_LOW: r_acc <= r_acc + prod_low;
            tlpid_pkg::ACC_DRIVE:   r_drive[i_cmd.lane] <= drive_next;
            default:                r_acc <= r_acc;
        endcase
    end

    // Output register.
    assign out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            for (int l = 0; l < tlpid_pkg::LANES; l++) begin
                r_out_drive[l] <= r_res_cmd ? r_drive[l] : '0;
            end
            r_out_cmd  <= r_res_cmd;
            r_out_conv <= r_done;
        end
    end

    assign o_sts.all_in   = all_in;
    assign o_sts.div_busy = div_busy;
    assign o_sts.out_free = out_free;

    assign o_valid         = r_out_valid;
    assign o_drive         = r_out_drive;
    assign o_command_valid = r_out_cmd;
    assign o_converged     = r_out_conv;

endmodule

`default_nettype wire

FILE: hw/rtl/three_lane_pid_with_convergence.sv
// ----------------------------------------------------------------------------
// three_lane_pid_with_convergence
// Three-lane PID current controller with a sticky convergence flag.
//
//   Channel   Direction  Handshake             Payload
//   tick      in         i_valid / o_ready     i_target_*, i_measured_*,
//                                              i_elapsed_us
//   command   out        o_valid / i_ready     o_drive_*, o_command_valid,
//                                              o_converged
//   config    in         i_cfg_we              i_cfg_index, i_cfg_data
//
// A beat that issues a command runs one check step, then the multiply,
// accumulate and divide steps of each lane in turn, then the output load.
// Each lane waits on the 17-step serial divider of the derivative.
// A converged beat goes from the check straight to the output load.
// Reset clears integrals, previous errors, gains and the flag and sets tolerance to 205.
// The output register holds a result until it is taken; a new beat is
// accepted meanwhile, and a finished result waits while that register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module three_lane_pid_with_convergence (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_we,
    input  wire logic        [tlpid_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic        [tlpid_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                                   i_valid,
    output logic                                        o_ready,
    input  wire logic signed [tlpid_pkg::CUR_W-1:0]     i_target_1,
    input  wire logic signed [tlpid_pkg::CUR_W-1:0]     i_target_2,
    input  wire logic signed [tlpid_pkg::CUR_W-1:0]     i_target_3,
    input  wire logic signed [tlpid_pkg::CUR_W-1:0]     i_measured_1,
    input  wire logic signed [tlpid_pkg::CUR_W-1:0]     i_measured_2,
    input  wire logic signed [tlpid_pkg::CUR_W-1:0]     i_measured_3,
    input  wire logic        [tlpid_pkg::DT_W-1:0]      i_elapsed_us,
    output logic                                        o_valid,
    input  wire logic                                   i_ready,
    output logic signed      [tlpid_pkg::DRIVE_W-1:0]   o_drive_1,
    output logic signed      [tlpid_pkg::DRIVE_W-1:0]   o_drive_2,
    output logic signed      [tlpid_pkg::DRIVE_W-1:0]   o_drive_3,
    output logic                                        o_command_valid,
    output logic                                        o_converged
);

    tlpid_pkg::t_dp_cmd                     dp_cmd;
    tlpid_pkg::t_dp_sts                     dp_sts;
    logic signed [tlpid_pkg::CUR_W-1:0]     target_arr   [tlpid_pkg::LANES];
    logic signed [tlpid_pkg::CUR_W-1:0]     measured_arr [tlpid_pkg::LANES];
    logic signed [tlpid_pkg::DRIVE_W-1:0]   drive_arr    [tlpid_pkg::LANES];

    assign target_arr[0]   = i_target_1;
    assign target_arr[1]   = i_target_2;
    assign target_arr[2]   = i_target_3;
    assign measured_arr[0] = i_measured_1;
    assign measured_arr[1] = i_measured_2;
    assign measured_arr[2] = i_measured_3;

    tlpid_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (dp_sts),
        .o_ready (o_ready),
        .o_cmd   (dp_cmd)
    );

    tlpid_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_sts           (dp_sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_target        (target_arr),
        .i_measured      (measured_arr),
        .i_elapsed_us    (i_elapsed_us),
        .i_ready         (i_ready),
        .o_valid         (o_valid),
        .o_drive         (drive_arr),
        .o_command_valid (o_command_valid),
        .o_converged     (o_converged)
    );

    assign o_drive_1 = drive_arr[0];
    assign o_drive_2 = drive_arr[1];
    assign o_drive_3 = drive_arr[2];

endmodule

`default_nettype wire
